FILE: rtl/lrsd_pkg.sv
// ----------------------------------------------------------------------------
// LRU stack reuse distance - shared definitions
// Sizes, control state encoding and the capacity clamp.
// ----------------------------------------------------------------------------
package lrsd_pkg;

    localparam int STACK_DEPTH = 256;
    localparam int IDX_W       = $clog2(STACK_DEPTH);
    localparam int OCC_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = 64;
    localparam int ID_W        = 32;
    localparam int CAP_W       = 9;
    localparam int DIST_W      = 9;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);

    localparam logic OP_ACCESS = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    typedef enum logic [0:0] {
        S_IDLE,
        S_UPDATE
    } t_state;

    // zero or anything above the depth means the full stack
    function automatic logic [OCC_W-1:0] eff_cap(input logic [CAP_W-1:0] cap);
        int c;
        c = int'(cap);
        if (c == 0 || c > STACK_DEPTH) begin
            c = STACK_DEPTH;
        end
        return OCC_W'(c);
    endfunction

endpackage

FILE: rtl/lrsd_cell.sv
// ----------------------------------------------------------------------------
// LRU stack cell
// One stack entry: compares against the broadcast address and takes the
// entry of its newer neighbor when the stack shifts.
// ----------------------------------------------------------------------------
module lrsd_cell (
    input  logic                        i_clk,
    input  logic                        i_capture,
    input  logic                        i_live,
    input  logic [lrsd_pkg::ADDR_W-1:0] i_cmp_addr,
    input  logic                        i_shift,
    input  logic [lrsd_pkg::ADDR_W-1:0] i_prev_addr,
    output logic [lrsd_pkg::ADDR_W-1:0] o_addr,
    output logic                        o_match
);

    logic [lrsd_pkg::ADDR_W-1:0] r_addr;
    logic                        r_match;

    always_ff @(posedge i_clk) begin
        if (i_capture) begin
            r_match <= i_live && (r_addr == i_cmp_addr);
        end
        if (i_shift) begin
            r_addr <= i_prev_addr;
        end
    end

    assign o_addr  = r_addr;
    assign o_match = r_match;

endmodule

FILE: rtl/lru_stack_reuse_distance_top.sv
// ----------------------------------------------------------------------------
// LRU stack reuse distance - top level
// Most-recently-used address stack built as a row of compare/shift cells.
//
// Input channel (i_in_valid / o_in_stall): one word per access or flush.
// An access is compared against every live cell in the cycle it is taken;
// in the update state that follows, once the output register is free, the
// matching position is encoded, the result word is written to the output
// register and the cells shift toward the oldest end (up to the hit
// position, or all of them on a miss) with the new address entering cell
// 0. The compare-then-shift pass keeps o_in_stall high for the whole update
// state. A flush empties the stack in idle and gives no result word.
// Output channel (o_out_valid / i_out_stall): one word per access, held
// while stalled. A new word may be taken while the previous result waits;
// the update cycle waits only if the output register is still full.
// Configuration (i_cfg_valid / o_cfg_ready): window capacity, which the user
// must write only while idle (not enforced); live depth is trimmed at once.
// Reset empties the stack and sets the capacity to the full depth.
// ----------------------------------------------------------------------------
module lru_stack_reuse_distance_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_opcode,
    input  logic [lrsd_pkg::ADDR_W-1:0] i_address,
    input  logic [lrsd_pkg::ID_W-1:0]   i_access_id,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_is_hit,
    output logic [lrsd_pkg::DIST_W-1:0] o_reuse_distance,
    output logic [lrsd_pkg::ID_W-1:0]   o_result_id,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [lrsd_pkg::CAP_W-1:0]  i_cfg_data
);

    localparam int D = lrsd_pkg::STACK_DEPTH;

    lrsd_pkg::t_state            r_state, n_state;
    logic [lrsd_pkg::OCC_W-1:0]  r_occ;
    logic [lrsd_pkg::CAP_W-1:0]  r_cap;
    logic [lrsd_pkg::ADDR_W-1:0] r_key;
    logic [lrsd_pkg::ID_W-1:0]   r_id;
    logic                        r_out_valid;
    logic                        r_hit;
    logic [lrsd_pkg::DIST_W-1:0] r_dist;
    logic [lrsd_pkg::ID_W-1:0]   r_rid;

    logic                        in_take;
    logic                        take_access;
    logic                        take_flush;
    logic                        cfg_take;
    logic                        out_free;
    logic                        do_update;
    logic                        in_stall;

    logic [lrsd_pkg::ADDR_W-1:0] cell_addr [D];
    logic [D-1:0]                match;
    logic                        hit;
    logic [lrsd_pkg::IDX_W-1:0]  pos;
    logic [lrsd_pkg::OCC_W-1:0]  cap_now;
    logic [lrsd_pkg::OCC_W-1:0]  cap_new;
    logic [lrsd_pkg::OCC_W:0]    occ_inc;
    logic [lrsd_pkg::IDX_W:0]    dist_full;

    assign in_take     = i_in_valid && !in_stall;
    assign take_access = in_take && (i_opcode == lrsd_pkg::OP_ACCESS);
    assign take_flush  = in_take && (i_opcode == lrsd_pkg::OP_FLUSH);
    assign cfg_take    = i_cfg_valid && o_cfg_ready;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign cap_now     = lrsd_pkg::eff_cap(r_cap);
    assign cap_new     = lrsd_pkg::eff_cap(i_cfg_data);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lrsd_pkg::S_IDLE: begin
                if (take_access) begin
                    n_state = lrsd_pkg::S_UPDATE;
                end
            end
            lrsd_pkg::S_UPDATE: begin
                if (out_free) begin
                    n_state = lrsd_pkg::S_IDLE;
                end
            end
            default: n_state = lrsd_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        in_stall  = 1'b1;
        do_update = 1'b0;
        case (r_state)
            lrsd_pkg::S_IDLE: begin
                in_stall = 1'b0;
            end
            lrsd_pkg::S_UPDATE: begin
                do_update = out_free;
            end
            default: begin
                in_stall  = 1'b1;
                do_update = 1'b0;
            end
        endcase
    end

    // cell row
    for (genvar g = 0; g < D; g++) begin : g_cell
        logic                        live;
        logic                        shift;
        logic [lrsd_pkg::ADDR_W-1:0] prev;

        assign live  = lrsd_pkg::OCC_W'(g) < r_occ;
        assign shift = do_update && (!hit || (lrsd_pkg::IDX_W'(g) <= pos));
        if (g == 0) begin : g_head
            assign prev = r_key;
        end else begin : g_body
            assign prev = cell_addr[g-1];
        end

        lrsd_cell u_cell (
            .i_clk       (i_clk),
            .i_capture   (take_access),
            .i_live      (live),
            .i_cmp_addr  (i_address),
            .i_shift     (shift),
            .i_prev_addr (prev),
            .o_addr      (cell_addr[g]),
            .o_match     (match[g])
        );
    end

    // stored addresses are distinct, so at most one cell matches
    always_comb begin
        pos = '0;
        for (int i = 0; i < D; i++) begin
            pos = pos | ({lrsd_pkg::IDX_W{match[i]}} & lrsd_pkg::IDX_W'(i));
        end
    end

    assign hit       = |match;
    assign dist_full = {1'b0, pos} + (lrsd_pkg::IDX_W+1)'(1);
    assign occ_inc   = {1'b0, r_occ} + (lrsd_pkg::OCC_W+1)'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lrsd_pkg::S_IDLE;
            r_occ       <= '0;
            r_cap       <= lrsd_pkg::CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_take) begin
                r_cap <= i_cfg_data;
                if (r_occ > cap_new) begin
                    r_occ <= cap_new;
                end
            end else if (take_flush) begin
                r_occ <= '0;
            end else if (do_update && !hit) begin
                if (occ_inc > {1'b0, cap_now}) begin
                    r_occ <= cap_now;
                end else begin
                    r_occ <= lrsd_pkg::OCC_W'(occ_inc);
                end
            end
            if (do_update) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_access) begin
            r_key <= i_address;
            r_id  <= i_access_id;
        end
        if (do_update) begin
            r_hit  <= hit;
            r_dist <= hit ? lrsd_pkg::DIST_W'(dist_full) : '0;
            r_rid  <= r_id;
        end
    end

    assign o_in_stall       = in_stall;
    assign o_out_valid      = r_out_valid;
    assign o_is_hit         = r_hit;
    assign o_reuse_distance = r_dist;
    assign o_result_id      = r_rid;
    assign o_cfg_ready      = 1'b1;

endmodule

FILE: rtl/lrsd_chk.sv
// ----------------------------------------------------------------------------
// LRU stack reuse distance - port checker
// Watches the top level ports; attached by bind.
// ----------------------------------------------------------------------------
module lrsd_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input logic                        i_opcode,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic                        o_is_hit,
    input logic [lrsd_pkg::DIST_W-1:0] o_reuse_distance,
    input logic [lrsd_pkg::ID_W-1:0]   o_result_id
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_reuse_distance) && $stable(o_result_id)
            && $stable(o_is_hit))
        else $error("result word changed while stalled");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_is_hit |-> o_reuse_distance == '0)
        else $error("miss with nonzero distance");

    a_hit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_hit |->
            o_reuse_distance != '0
            && o_reuse_distance <= lrsd_pkg::DIST_W'(lrsd_pkg::STACK_DEPTH))
        else $error("hit distance out of range");

    // an access holds off the next word for its update cycle
    a_access_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_opcode == lrsd_pkg::OP_ACCESS |=> o_in_stall)
        else $error("word taken during update cycle");

endmodule

bind lru_stack_reuse_distance_top lrsd_chk u_lrsd_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_stall       (o_in_stall),
    .i_opcode         (i_opcode),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_is_hit         (o_is_hit),
    .o_reuse_distance (o_reuse_distance),
    .o_result_id      (o_result_id)
);

FILE: bench/tb_lru_stack_reuse_distance_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LRU stack reuse distance - testbench
// Streams access and flush words into the block with random idling on both
// channels, keeps its own MRU address stack in step with every accepted
// word and checks each result word against it. The window capacity is
// changed between phases once the block has drained, including trims of a
// well filled stack, zero and oversized values.
// ----------------------------------------------------------------------------
module tb_lru_stack_reuse_distance_top;

    typedef struct packed {
        logic                        opcode;
        logic [lrsd_pkg::ADDR_W-1:0] address;
        logic [lrsd_pkg::ID_W-1:0]   access_id;
    } t_access_word;

    typedef struct packed {
        logic                        is_hit;
        logic [lrsd_pkg::DIST_W-1:0] distance;
        logic [lrsd_pkg::ID_W-1:0]   result_id;
    } t_reuse_word;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_stall;
    logic                        i_opcode = lrsd_pkg::OP_ACCESS;
    logic [lrsd_pkg::ADDR_W-1:0] i_address = '0;
    logic [lrsd_pkg::ID_W-1:0]   i_access_id = '0;
    logic                        o_out_valid;
    logic                        i_out_stall = 1'b0;
    logic                        o_is_hit;
    logic [lrsd_pkg::DIST_W-1:0] o_reuse_distance;
    logic [lrsd_pkg::ID_W-1:0]   o_result_id;
    logic                        i_cfg_valid = 1'b0;
    logic                        o_cfg_ready;
    logic [lrsd_pkg::CAP_W-1:0]  i_cfg_data = '0;

    t_access_word                feed_q[$];
    t_reuse_word                 expected_reuse_q[$];
    logic [lrsd_pkg::ADDR_W-1:0] mru_stack[$];      // newest address at index 0
    logic [lrsd_pkg::CAP_W-1:0]  window_cap = lrsd_pkg::CAP_RESET;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int          send_gap = 0;
    int          stall_gap = 0;
    int          fault_count = 0;

    always #5 i_clk = ~i_clk;

    lru_stack_reuse_distance_top DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_opcode         (i_opcode),
        .i_address        (i_address),
        .i_access_id      (i_access_id),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_is_hit         (o_is_hit),
        .o_reuse_distance (o_reuse_distance),
        .o_result_id      (o_result_id),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data)
    );

    function automatic int live_depth();
        return (window_cap == '0 ||
                window_cap > lrsd_pkg::CAP_W'(lrsd_pkg::STACK_DEPTH)) ?
               lrsd_pkg::STACK_DEPTH : int'(window_cap);
    endfunction

    // search the live window, then move the address to the top
    function automatic t_reuse_word promote_address(
        input logic [lrsd_pkg::ADDR_W-1:0] addr,
        input logic [lrsd_pkg::ID_W-1:0]   id
    );
        t_reuse_word word;
        int          pos;
        pos = -1;
        for (int k = 0; k < mru_stack.size(); k++) begin
            if (pos < 0 && mru_stack[k] == addr) begin
                pos = k;
            end
        end
        word.result_id = id;
        if (pos >= 0) begin
            word.is_hit   = 1'b1;
            word.distance = lrsd_pkg::DIST_W'(pos + 1);
            mru_stack.delete(pos);
        end else begin
            word.is_hit   = 1'b0;
            word.distance = '0;
        end
        mru_stack.insert(0, addr);
        while (mru_stack.size() > live_depth()) begin
            mru_stack.delete(mru_stack.size() - 1);
        end
        return word;
    endfunction

    // input side: words leave the queue only when the channel is free
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap   <= 0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (i_in_valid) begin
                if (i_opcode == lrsd_pkg::OP_FLUSH) begin
                    mru_stack.delete();
                end else begin
                    expected_reuse_q.insert(expected_reuse_q.size(),
                                            promote_address(i_address, i_access_id));
                end
            end
            if (send_gap > 0) begin
                send_gap   <= send_gap - 1;
                i_in_valid <= 1'b0;
            end else if (feed_q.size() == 0) begin
                i_in_valid <= 1'b0;
            end else if ($urandom_range(0, 99) < send_idle_pct) begin
                send_gap   <= $urandom_range(0, 16);
                i_in_valid <= 1'b0;
            end else begin
                i_in_valid <= 1'b1;
                {i_opcode, i_address, i_access_id} <= feed_q[0];
                feed_q.delete(0);
            end
        end
    end

    // output side: check each taken word, stall in random bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_gap   <= 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_reuse_q.size() == 0) begin
                    fault_count++;
                    if (fault_count <= 10) begin
                        $display("unexpected result word: hit=%0b dist=%0d id=%08h",
                                 o_is_hit, o_reuse_distance, o_result_id);
                    end
                end else begin
                    if (o_is_hit !== expected_reuse_q[0].is_hit ||
                        o_reuse_distance !== expected_reuse_q[0].distance ||
                        o_result_id !== expected_reuse_q[0].result_id) begin
                        fault_count++;
                        if (fault_count <= 10) begin
                            $display({"mismatch: expected hit=%0b dist=%0d id=%08h,",
                                      " got hit=%0b dist=%0d id=%08h"},
                                     expected_reuse_q[0].is_hit,
                                     expected_reuse_q[0].distance,
                                     expected_reuse_q[0].result_id,
                                     o_is_hit, o_reuse_distance, o_result_id);
                        end
                    end
                    expected_reuse_q.delete(0);
                end
            end
            if (stall_gap > 0) begin
                stall_gap   <= stall_gap - 1;
                i_out_stall <= 1'b1;
            end else if ($urandom_range(0, 99) < recv_idle_pct) begin
                stall_gap   <= $urandom_range(0, 16);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic queue_access(input logic [lrsd_pkg::ADDR_W-1:0] addr,
                                input logic [lrsd_pkg::ID_W-1:0]   id);
        t_access_word word;
        word.opcode    = lrsd_pkg::OP_ACCESS;
        word.address   = addr;
        word.access_id = id;
        feed_q.insert(feed_q.size(), word);
    endtask

    task automatic queue_flush();
        t_access_word word;
        word.opcode    = lrsd_pkg::OP_FLUSH;
        word.address   = {$urandom, $urandom};
        word.access_id = $urandom;
        feed_q.insert(feed_q.size(), word);
    endtask

    // hot set for short distances, wider pool for deep ones, some noise
    task automatic queue_mixed(input int count, input bit end_flush);
        logic [lrsd_pkg::ADDR_W-1:0] pool[$];
        logic [lrsd_pkg::ADDR_W-1:0] base;
        int                          span;
        int                          hot;
        int                          roll;
        base = {$urandom, $urandom};
        span = $urandom_range(live_depth() / 2 + 1, live_depth() + live_depth() / 4 + 2);
        hot  = (span < 4) ? span : 4;
        for (int k = 0; k < span; k++) begin
            // single-bit neighbors exercise randomly chosen compare bits
            if ($urandom_range(0, 1) == 0) begin
                pool.insert(pool.size(), base ^ (64'd1 << $urandom_range(0, 63)));
            end else begin
                pool.insert(pool.size(), {$urandom, $urandom});
            end
        end
        for (int k = 0; k < count; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                queue_flush();
            end else if (roll < 10) begin
                queue_access({$urandom, $urandom}, $urandom);
            end else if (roll < 35) begin
                queue_access(pool[$urandom_range(0, hot - 1)], $urandom);
            end else begin
                queue_access(pool[$urandom_range(0, span - 1)], $urandom);
            end
        end
        if (end_flush) begin
            queue_flush();
        end
    endtask

    // round robin over distinct addresses: deepest hits or pure thrash
    task automatic queue_cycle(input int span, input int count);
        logic [lrsd_pkg::ADDR_W-1:0] base;
        base = {$urandom, $urandom};
        for (int k = 0; k < count; k++) begin
            queue_access(base + lrsd_pkg::ADDR_W'(k % span) * 64'h9E37_79B9_7F4A_7C15,
                         $urandom);
        end
    endtask

    task automatic settle();
        while (feed_q.size() != 0 || i_in_valid || expected_reuse_q.size() != 0) begin
            @(negedge i_clk);
        end
        // extra margin before the next configuration write
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [lrsd_pkg::CAP_W-1:0] cap);
        logic [lrsd_pkg::ADDR_W-1:0] snap[$];
        settle();
        snap = mru_stack;
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cap;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        window_cap = cap;
        while (mru_stack.size() > live_depth()) begin
            mru_stack.delete(mru_stack.size() - 1);
        end
        @(negedge i_clk);
        // touch both ends of the old stack; trimmed entries must miss
        if (snap.size() > 0) begin
            queue_access(snap[snap.size() - 1], $urandom);
            queue_access(snap[snap.size() / 2], $urandom);
            queue_access(snap[0], $urandom);
            if (snap.size() > 2) begin
                queue_access(snap[2], $urandom);
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle_pct = 25;
        recv_idle_pct = 25;
        queue_access('0, '0);
        queue_access('0, '1);
        queue_access('1, 32'hA5A5_A5A5);
        queue_access('0, 32'h5A5A_5A5A);
        queue_access(64'h8000_0000_0000_0000, $urandom);
        queue_access('1, $urandom);
        queue_access(64'h5555_5555_5555_5555, $urandom);
        queue_access(64'hAAAA_AAAA_AAAA_AAAA, $urandom);
        queue_access(64'h0000_0000_0000_0001, $urandom);
        queue_access('0, $urandom);
        queue_flush();
        queue_flush();
        queue_access('0, $urandom);
        queue_access(64'h8000_0000_0000_0000, $urandom);
        queue_access('0, $urandom);
        queue_access('0, $urandom);
        queue_access(64'h8000_0000_0000_0000, $urandom);

        write_capacity(9'd256);
        send_idle_pct = 30;
        recv_idle_pct = 30;
        queue_mixed(150, 1'b0);

        // trim a well filled stack down to three
        write_capacity(9'd3);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_mixed(120, 1'b1);

        write_capacity(9'd1);
        send_idle_pct = 50;
        recv_idle_pct = 20;
        queue_mixed(100, 1'b1);

        write_capacity(9'd2);
        send_idle_pct = 20;
        recv_idle_pct = 50;
        queue_mixed(100, 1'b1);

        // zero means full depth: fill, then hit at the bottom every time
        write_capacity(9'd0);
        send_idle_pct = 10;
        recv_idle_pct = 10;
        queue_cycle(lrsd_pkg::STACK_DEPTH, lrsd_pkg::STACK_DEPTH + 60);
        queue_mixed(60, 1'b1);

        // oversized value saturates, so one address more than depth thrashes
        write_capacity(9'd511);
        queue_cycle(lrsd_pkg::STACK_DEPTH + 1, lrsd_pkg::STACK_DEPTH + 44);

        write_capacity(9'd300);
        send_idle_pct = 30;
        recv_idle_pct = 30;
        queue_mixed(120, 1'b1);

        write_capacity(9'd255);
        send_idle_pct = 60;
        recv_idle_pct = 60;
        queue_mixed(120, 1'b1);

        write_capacity(9'd17);
        send_idle_pct = 20;
        recv_idle_pct = 0;
        queue_mixed(150, 1'b1);

        write_capacity(9'd64);
        send_idle_pct = 0;
        recv_idle_pct = 30;
        queue_mixed(150, 1'b0);

        write_capacity(9'd5);
        send_idle_pct = 40;
        recv_idle_pct = 40;
        queue_mixed(100, 1'b1);

        write_capacity(9'd256);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_mixed(200, 1'b0);

        settle();
        repeat (20) @(posedge i_clk);
        if (fault_count == 0 && expected_reuse_q.size() == 0) begin
            $display("PASS lru_stack_reuse_distance_top");
        end else begin
            $display("FAIL lru_stack_reuse_distance_top");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("FAIL lru_stack_reuse_distance_top");
        $finish;
    end

endmodule
